>>> sv/fca_pkg.sv
// Shared constants, types and helpers of the frame cumulative average block.
package fca_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_COUNT_BITS = 16;

  localparam int CFG_BITS      = 11;
  localparam int PADDR_BITS    = 3;
  localparam int APB_DATA_BITS = 32;

  localparam int CH_BITS  = 8;
  localparam int NUM_CH   = 3;
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // The quotient is one channel wide; the divider resolves two bits per stage.
  localparam int QUO_BITS      = CH_BITS;
  localparam int BITS_PER_STEP = 2;
  localparam int DIV_STAGES    = QUO_BITS / BITS_PER_STEP;
  // Stage 1 holds the store read, stage 2 the dividend, then the divider steps.
  localparam int LANE_STAGES   = DIV_STAGES + 1;

  typedef struct packed {
    logic [LANE_STAGES-1:0] load;
    logic                   wr_en;
  } fca_lane_ctl_t;

  function automatic int bits_for(int count);
    return (count > 1) ? $clog2(count) : 1;
  endfunction

endpackage

>>> sv/fca_pixel_if.sv
// Stream interface that carries one RGB pixel request per handshake.
interface fca_pixel_if import fca_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CH_BITS-1:0] pixel_red;
  logic [CH_BITS-1:0] pixel_green;
  logic [CH_BITS-1:0] pixel_blue;

  modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                  input ready);
  modport sink (input valid, input pixel_red, input pixel_green, input pixel_blue,
                output ready);
endinterface

>>> sv/fca_avg_if.sv
// Stream interface that carries one averaged pixel result per handshake.
interface fca_avg_if import fca_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CH_BITS-1:0] avg_red;
  logic [CH_BITS-1:0] avg_green;
  logic [CH_BITS-1:0] avg_blue;
  logic               frame_end;

  modport source (output valid, output avg_red, output avg_green, output avg_blue,
                  output frame_end, input ready);
  modport sink (input valid, input avg_red, input avg_green, input avg_blue,
                input frame_end, output ready);
endinterface

>>> sv/frame_cumulative_average.sv
// Per-pixel cumulative moving average of a raster video stream.
//
// The pixel channel takes one RGB request per handshake in raster order; the avg
// channel returns one request per pixel with the updated averages
// floor((pixel + n*avg) / (n + 1)), n being the number of frames already seen,
// and frame_end set on the last pixel of the frame. Frame size comes from the
// APB registers frame_width (0x0) and frame_height (0x4).
// An accepted pixel passes the store read, dividend and divider stages and then
// the merge register. One pixel is taken per cycle unless the avg channel stalls
// or a store hazard holds it: three color lanes run in parallel, each with its
// own slice of the average store and a four-stage divider that resolves two
// quotient bits per stage. A pixel whose store entry is in the pipeline waits
// for its write-back; this only happens when a frame has fewer than six pixels.
// Reset clears the position and frame count and sets the size to 640 by 480. The
// store is not cleared: the first frame runs with a count of zero and ignores it.
// When the receiver stalls, results collect in the pipeline stages; pixel ready
// drops once all six stages hold a pixel and rises again as results drain.
module frame_cumulative_average import fca_pkg::*; #(
  parameter int  MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int  MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int  COUNT_BITS = DEF_COUNT_BITS,
  localparam int ADDR_BITS  = bits_for(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_BITS-1:0]    paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  fca_pixel_if.sink                pixel,
  fca_avg_if.source                avg
);

  logic [CFG_BITS-1:0]                 width_eff;
  logic [CFG_BITS-1:0]                 height_eff;
  logic                                merge_ready;
  fca_lane_ctl_t                       ctl;
  logic [ADDR_BITS-1:0]                rd_addr;
  logic [ADDR_BITS-1:0]                wr_addr;
  logic [COUNT_BITS-1:0]               count;
  logic [DIV_STAGES-1:0][COUNT_BITS:0] divisor;
  logic                                frame_end;
  logic [NUM_CH-1:0][CH_BITS-1:0]      px_ch;
  logic [NUM_CH-1:0][CH_BITS-1:0]      lane_result;

  fca_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .width_eff  (width_eff),
    .height_eff (height_eff)
  );

  fca_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .width       (width_eff),
    .height      (height_eff),
    .in_valid    (pixel.valid),
    .in_ready    (pixel.ready),
    .merge_ready (merge_ready),
    .ctl         (ctl),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .count       (count),
    .divisor     (divisor),
    .frame_end   (frame_end)
  );

  assign px_ch[CH_RED]   = pixel.pixel_red;
  assign px_ch[CH_GREEN] = pixel.pixel_green;
  assign px_ch[CH_BLUE]  = pixel.pixel_blue;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    fca_lane #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .COUNT_BITS (COUNT_BITS)
    ) u_lane (
      .clk     (clk),
      .ctl     (ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .count   (count),
      .divisor (divisor),
      .px      (px_ch[c]),
      .result  (lane_result[c])
    );
  end

  fca_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .lane_result (lane_result),
    .frame_end   (frame_end),
    .merge_ready (merge_ready),
    .avg         (avg)
  );

endmodule

>>> sv/fca_regs.sv
// APB configuration registers for frame size, with range clamping.
module fca_regs import fca_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_BITS-1:0]    paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output logic [CFG_BITS-1:0]      width_eff,
  output logic [CFG_BITS-1:0]      height_eff
);

  localparam logic [CFG_BITS-1:0] RESET_WIDTH  = CFG_BITS'(640);
  localparam logic [CFG_BITS-1:0] RESET_HEIGHT = CFG_BITS'(480);

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  logic [CFG_BITS-1:0] frame_width;
  logic [CFG_BITS-1:0] frame_height;
  reg_idx_t            reg_sel;
  logic                wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
    end else if (wr) begin
      unique case (reg_sel)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[CFG_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FRAME_WIDTH:  prdata = APB_DATA_BITS'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_BITS'(frame_height);
      default:          prdata = '0;
    endcase
  end

  // A size of zero acts as one; a size above the store acts as the store limit.
  always_comb begin
    if (frame_width == '0) begin
      width_eff = CFG_BITS'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      width_eff = CFG_BITS'(MAX_WIDTH);
    end else begin
      width_eff = frame_width;
    end
    if (frame_height == '0) begin
      height_eff = CFG_BITS'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      height_eff = CFG_BITS'(MAX_HEIGHT);
    end else begin
      height_eff = frame_height;
    end
  end

endmodule

>>> sv/fca_seq.sv
// Raster sequencer: position and frame count, store hazard check, pipeline control.
module fca_seq import fca_pkg::*; #(
  parameter int  MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int  MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int  COUNT_BITS = DEF_COUNT_BITS,
  localparam int ADDR_BITS  = bits_for(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [CFG_BITS-1:0]                  width,
  input  logic [CFG_BITS-1:0]                  height,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 merge_ready,
  output fca_lane_ctl_t                        ctl,
  output logic [ADDR_BITS-1:0]                 rd_addr,
  output logic [ADDR_BITS-1:0]                 wr_addr,
  output logic [COUNT_BITS-1:0]                count,
  output logic [DIV_STAGES-1:0][COUNT_BITS:0]  divisor,
  output logic                                 frame_end
);

  localparam int COL_BITS = bits_for(MAX_WIDTH);
  localparam int ROW_BITS = bits_for(MAX_HEIGHT);
  localparam int POS_BITS = ((COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS) + 1;
  localparam int CMPW     = (POS_BITS > CFG_BITS) ? POS_BITS : CFG_BITS;

  logic [COL_BITS-1:0]   col;
  logic [ROW_BITS-1:0]   row;
  logic [ADDR_BITS-1:0]  row_base;
  logic [ADDR_BITS-1:0]  addr_now;
  logic [COUNT_BITS-1:0] frames_seen;
  logic                  line_end;
  logic                  row_end;
  logic                  frame_last;
  logic                  hazard;
  logic                  accept;

  logic [LANE_STAGES:1]   stage_valid;
  logic [LANE_STAGES:1]   stage_last;
  logic [ADDR_BITS-1:0]   stage_addr [1:LANE_STAGES];
  logic [LANE_STAGES+1:1] rdy;
  logic [COUNT_BITS-1:0]  count1;
  logic [DIV_STAGES-1:0][COUNT_BITS:0] dvs;

  always_comb begin
    line_end   = (CMPW'(col) + CMPW'(1)) >= CMPW'(width);
    row_end    = (CMPW'(row) + CMPW'(1)) >= CMPW'(height);
    frame_last = line_end && row_end;
    addr_now   = row_base + ADDR_BITS'(col);
  end

  // An entry still in flight has not been written back yet, so the request waits.
  always_comb begin
    hazard = 1'b0;
    for (int k = 1; k <= LANE_STAGES; k++) begin
      if (stage_valid[k] && (stage_addr[k] == addr_now)) hazard = 1'b1;
    end
  end

  always_comb begin
    rdy[LANE_STAGES+1] = merge_ready;
    for (int k = LANE_STAGES; k >= 1; k--) begin
      rdy[k] = !stage_valid[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[1] && !hazard;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ctl.load[0] = accept;
    for (int k = 2; k <= LANE_STAGES; k++) begin
      ctl.load[k-1] = rdy[k] && stage_valid[k-1];
    end
    ctl.wr_en = stage_valid[LANE_STAGES] && rdy[LANE_STAGES+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col         <= '0;
      row         <= '0;
      row_base    <= '0;
      frames_seen <= '0;
      stage_valid <= '0;
    end else begin
      if (accept) begin
        if (line_end) begin
          col <= '0;
          if (row_end) begin
            row      <= '0;
            row_base <= '0;
          end else begin
            row      <= row + ROW_BITS'(1);
            row_base <= row_base + ADDR_BITS'(MAX_WIDTH);
          end
        end else begin
          col <= col + COL_BITS'(1);
        end
        if (frame_last && (frames_seen != '1)) frames_seen <= frames_seen + COUNT_BITS'(1);
      end
      for (int k = 1; k <= LANE_STAGES; k++) begin
        if (rdy[k]) begin
          if (k == 1) stage_valid[k] <= accept;
          else        stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      stage_addr[1] <= addr_now;
      stage_last[1] <= frame_last;
      count1        <= frames_seen;
    end
    for (int k = 2; k <= LANE_STAGES; k++) begin
      if (ctl.load[k-1]) begin
        stage_addr[k] <= stage_addr[k-1];
        stage_last[k] <= stage_last[k-1];
      end
    end
    if (ctl.load[1]) dvs[0] <= {1'b0, count1} + (COUNT_BITS+1)'(1);
    for (int j = 1; j < DIV_STAGES; j++) begin
      if (ctl.load[j+1]) dvs[j] <= dvs[j-1];
    end
  end

  assign rd_addr   = addr_now;
  assign wr_addr   = stage_addr[LANE_STAGES];
  assign count     = count1;
  assign divisor   = dvs;
  assign frame_end = stage_last[LANE_STAGES];

`ifndef SYNTHESIS
  a_distinct_in_flight: assert property (@(posedge clk) disable iff (rst)
    (stage_valid[1] && stage_valid[2]) |-> (stage_addr[1] != stage_addr[2]))
    else $error("two requests for the same store entry are in flight");

  a_last_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (stage_valid[LANE_STAGES] && !rdy[LANE_STAGES+1]) |=>
    (stage_valid[LANE_STAGES] && $stable(stage_addr[LANE_STAGES])))
    else $error("last lane stage lost its entry while the merge stage was full");

  a_count_only_at_frame_end: assert property (@(posedge clk) disable iff (rst)
    (accept && !frame_last) |=> $stable(frames_seen))
    else $error("frame count moved inside a frame");

  a_wrap_at_frame_end: assert property (@(posedge clk) disable iff (rst)
    (accept && frame_last) |=> ((col == '0) && (row == '0) && (row_base == '0)))
    else $error("position did not return to the origin after the last pixel");
`endif

endmodule

>>> sv/fca_lane.sv
// One color lane: average store slice, multiply-add and pipelined restoring divider.
module fca_lane import fca_pkg::*; #(
  parameter int  MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int  MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int  COUNT_BITS = DEF_COUNT_BITS,
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT,
  localparam int ADDR_BITS  = bits_for(DEPTH)
) (
  input  logic                                clk,
  input  fca_lane_ctl_t                       ctl,
  input  logic [ADDR_BITS-1:0]                rd_addr,
  input  logic [ADDR_BITS-1:0]                wr_addr,
  input  logic [COUNT_BITS-1:0]               count,
  input  logic [DIV_STAGES-1:0][COUNT_BITS:0] divisor,
  input  logic [CH_BITS-1:0]                  px,
  output logic [CH_BITS-1:0]                  result
);

  // The dividend stays below 256 times the divisor, so the quotient fits a channel.
  localparam int NW = COUNT_BITS + CH_BITS;

  logic [CH_BITS-1:0]  mem [DEPTH];
  logic [CH_BITS-1:0]  px1;
  logic [CH_BITS-1:0]  avg1;
  logic [CH_BITS-1:0]  avg_used;
  logic [NW-1:0]       dividend;
  logic [NW-1:0]       rem_r    [DIV_STAGES];
  logic [QUO_BITS-1:0] quo_r    [DIV_STAGES];
  logic [NW-1:0]       step_rem [DIV_STAGES];
  logic [QUO_BITS-1:0] step_quo [DIV_STAGES];

  function automatic logic [QUO_BITS+NW-1:0] div_step(
    logic [NW-1:0]       rem_in,
    logic [QUO_BITS-1:0] quo_in,
    logic [COUNT_BITS:0] dvs,
    int                  first_bit
  );
    logic [NW-1:0]       r;
    logic [QUO_BITS-1:0] q;
    logic [NW-1:0]       trial;
    r = rem_in;
    q = quo_in;
    for (int t = 0; t < BITS_PER_STEP; t++) begin
      trial = NW'(dvs) << (first_bit - t);
      if (r >= trial) begin
        r = r - trial;
        q[first_bit - t] = 1'b1;
      end
    end
    return {q, r};
  endfunction

  // On the first frame the store has never been written and the count is zero.
  assign avg_used = (count == '0) ? '0 : avg1;
  assign dividend = NW'(px1) + NW'(count) * NW'(avg_used);

  always_comb begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      {step_quo[j], step_rem[j]} = div_step(rem_r[j], quo_r[j], divisor[j],
                                            QUO_BITS - 1 - j * BITS_PER_STEP);
    end
  end

  assign result = step_quo[DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      px1  <= px;
      avg1 <= mem[rd_addr];
    end
    if (ctl.load[1]) begin
      rem_r[0] <= dividend;
      quo_r[0] <= '0;
    end
    for (int j = 1; j < DIV_STAGES; j++) begin
      if (ctl.load[j+1]) begin
        rem_r[j] <= step_rem[j-1];
        quo_r[j] <= step_quo[j-1];
      end
    end
    if (ctl.wr_en) mem[wr_addr] <= result;
  end

endmodule

>>> sv/fca_merge.sv
// Merge stage: joins the three lane results and the frame flag into the output register.
module fca_merge import fca_pkg::*; (
  input  logic                            clk,
  input  logic                            rst,
  input  fca_lane_ctl_t                   ctl,
  input  logic [NUM_CH-1:0][CH_BITS-1:0]  lane_result,
  input  logic                            frame_end,
  output logic                            merge_ready,
  fca_avg_if.source                       avg
);

  logic                           valid;
  logic [NUM_CH-1:0][CH_BITS-1:0] rgb;
  logic                           last;

  assign merge_ready = !valid || avg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (merge_ready) begin
      valid <= ctl.wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      rgb  <= lane_result;
      last <= frame_end;
    end
  end

  assign avg.valid     = valid;
  assign avg.avg_red   = rgb[CH_RED];
  assign avg.avg_green = rgb[CH_GREEN];
  assign avg.avg_blue  = rgb[CH_BLUE];
  assign avg.frame_end = last;

endmodule

>>> tb/tb_top.sv
// Self-checking bench for the frame cumulative average block with its own averaging predictor.
module tb_top;
  import fca_pkg::*;

  localparam int FRAME_MAX_W = DEF_MAX_WIDTH;
  localparam int FRAME_MAX_H = DEF_MAX_HEIGHT;
  localparam int COUNT_TOP   = (1 << DEF_COUNT_BITS) - 1;
  localparam int STALL_LIMIT = 4000;
  localparam int REPORT_CAP  = 40;
  localparam int REGION_W    = 24;
  localparam int REGION_H    = 16;

  typedef enum int {
    REG_WIDTH  = 0,
    REG_HEIGHT = 1
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
    logic [7:0]         gap;
  } pixel_req_t;

  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
    logic               frame_end;
  } avg_result_t;

  logic                     clk;
  logic                     rst     = 1'b1;
  logic                     psel    = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite  = 1'b0;
  logic [PADDR_BITS-1:0]    paddr   = '0;
  logic [APB_DATA_BITS-1:0] pwdata  = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  logic               pix_valid = 1'b0;
  logic [CH_BITS-1:0] pix_red   = '0;
  logic [CH_BITS-1:0] pix_green = '0;
  logic [CH_BITS-1:0] pix_blue  = '0;
  logic               avg_ready = 1'b0;

  fca_pixel_if pix_bus ();
  fca_avg_if   avg_bus ();

  assign pix_bus.valid       = pix_valid;
  assign pix_bus.pixel_red   = pix_red;
  assign pix_bus.pixel_green = pix_green;
  assign pix_bus.pixel_blue  = pix_blue;
  assign avg_bus.ready       = avg_ready;

  frame_cumulative_average u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pixel   (pix_bus),
    .avg     (avg_bus)
  );

  // Predictor state: shadow of the average store, frame size, raster position and count.
  logic [3*CH_BITS-1:0] average_shadow [int];
  logic [CFG_BITS-1:0]  cfg_width   = 11'd640;
  logic [CFG_BITS-1:0]  cfg_height  = 11'd480;
  int unsigned          frames_seen = 0;
  int                   col_at      = 0;
  int                   row_at      = 0;

  avg_result_t avg_pending [$];
  pixel_req_t  pixel_q [$];
  pixel_req_t  offer      = '0;
  bit          offer_live = 1'b0;
  bit          gap_armed  = 1'b0;
  int          gap_left   = 0;

  int results_seen  = 0;
  int mismatches    = 0;
  int frames_done   = 0;
  int sizes_tried   = 0;
  int random_sent   = 0;
  int directed_sent = 0;
  int sat_sent      = 0;
  int hold_left     = 0;
  int calm_left     = 0;
  int stall_left    = 0;
  bit hold_done     = 1'b0;
  int quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int fit_size(int v, int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // Advances the raster position by one pixel; returns 1 when the pixel closes the frame.
  function automatic bit step_raster(input int w, input int h, inout int c, inout int r);
    if (c + 1 >= w) begin
      c = 0;
      if (r + 1 >= h) begin
        r = 0;
        return 1'b1;
      end
      r++;
    end else begin
      c++;
    end
    return 1'b0;
  endfunction

  function automatic logic [CH_BITS-1:0] running_mean(logic [CH_BITS-1:0] px,
                                                     logic [CH_BITS-1:0] prev,
                                                     int unsigned n);
    longint unsigned num;
    longint unsigned den;
    num = longint'(px) + longint'(n) * longint'(prev);
    den = longint'(n) + 1;
    return CH_BITS'(num / den);
  endfunction

  function automatic void report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= REPORT_CAP)
      $display("mismatch after %0d results: %s got %0d, expected %0d",
               results_seen, what, got, want);
  endfunction

  function automatic void predict_average(pixel_req_t p);
    int                   addr;
    logic [3*CH_BITS-1:0] prev;
    logic [3*CH_BITS-1:0] upd;
    bit                   last;
    avg_result_t          e;
    addr = row_at * FRAME_MAX_W + col_at;
    prev = average_shadow.exists(addr) ? average_shadow[addr] : '0;
    upd  = {running_mean(p.red,   prev[23:16], frames_seen),
            running_mean(p.green, prev[15:8],  frames_seen),
            running_mean(p.blue,  prev[7:0],   frames_seen)};
    average_shadow[addr] = upd;
    last = step_raster(fit_size(cfg_width, FRAME_MAX_W), fit_size(cfg_height, FRAME_MAX_H),
                       col_at, row_at);
    if (last && frames_seen < COUNT_TOP) frames_seen++;
    if (last) frames_done++;
    e.red       = upd[23:16];
    e.green     = upd[15:8];
    e.blue      = upd[7:0];
    e.frame_end = last;
    avg_pending.push_back(e);
  endfunction

  function automatic void check_result();
    avg_result_t e;
    if (avg_pending.size() == 0) begin
      report_mismatch("result with no pixel pending", 1, 0);
    end else begin
      e = avg_pending.pop_front();
      if (avg_bus.avg_red !== e.red)
        report_mismatch("avg_red", avg_bus.avg_red, e.red);
      if (avg_bus.avg_green !== e.green)
        report_mismatch("avg_green", avg_bus.avg_green, e.green);
      if (avg_bus.avg_blue !== e.blue)
        report_mismatch("avg_blue", avg_bus.avg_blue, e.blue);
      if (avg_bus.frame_end !== e.frame_end)
        report_mismatch("frame_end", avg_bus.frame_end, e.frame_end);
    end
    results_seen++;
  endfunction

  // How many pixels can follow from the current position without reading a store entry
  // that was never written. A cut run stops one pixel early so that the position it
  // leaves behind still points at a written entry.
  function automatic int safe_run_length(int w, int h, int want);
    bit          touched [int];
    int          c;
    int          r;
    int          k;
    int          addr;
    int unsigned n;
    c = col_at;
    r = row_at;
    n = frames_seen;
    for (k = 0; k < want; k++) begin
      addr = r * FRAME_MAX_W + c;
      if (n != 0 && !average_shadow.exists(addr) && !touched.exists(addr))
        return (k > 0) ? k - 1 : 0;
      touched[addr] = 1'b1;
      if (step_raster(w, h, c, r) && n < COUNT_TOP) n++;
    end
    return want;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_dim(int region);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      5:       return region;
      6:       return 1024;
      7:       return 2047;
      8:       return $urandom_range(1023, 1025);
      9:       return $urandom_range(0, 2047);
      default: return $urandom_range(1, region);
    endcase
  endfunction

  function automatic logic [3*CH_BITS-1:0] directed_pixel(int k);
    case (k)
      0:  return 24'h000000;
      1:  return 24'hFFFFFF;
      2:  return 24'hFF0000;
      3:  return 24'h00FF00;
      4:  return 24'h0000FF;
      5:  return 24'h010204;
      6:  return 24'h081020;
      7:  return 24'h4080FE;
      8:  return 24'h804001;
      9:  return 24'hAA55AA;
      10: return 24'h55AA55;
      11: return 24'h7F80FF;
      12: return 24'hFFFFFF;
      13: return 24'h000000;
      14: return 24'h00FFFF;
      15: return 24'hFF00FF;
      16: return 24'hFFFF00;
      17: return 24'h000105;
      18: return 24'h091121;
      19: return 24'h3F81FF;
      20: return 24'h7F41FE;
      21: return 24'h55AA55;
      22: return 24'hAA55AA;
      default: return 24'h807FFE;
    endcase
  endfunction

  task automatic cfg_read(cfg_reg_e idx, logic [CFG_BITS-1:0] want);
    logic [APB_DATA_BITS-1:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PADDR_BITS'(int'(idx) * 4);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[CFG_BITS-1:0] !== want)
      report_mismatch(idx == REG_WIDTH ? "frame_width readback" : "frame_height readback",
                      got[CFG_BITS-1:0], want);
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [CFG_BITS-1:0] value);
    logic [APB_DATA_BITS-1:0] word;
    // Bits above the register are noise and must be dropped by the block.
    word = $urandom;
    word[CFG_BITS-1:0] = value;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_BITS'(int'(idx) * 4);
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WIDTH) cfg_width = value;
    else cfg_height = value;
    cfg_read(idx, value);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pixel_q.size() != 0 || offer_live || avg_pending.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_size(int w, int h);
    wait_drained();
    cfg_write(REG_WIDTH, CFG_BITS'(w));
    cfg_write(REG_HEIGHT, CFG_BITS'(h));
    sizes_tried++;
  endtask

  task automatic queue_pixel(logic [3*CH_BITS-1:0] rgb, int gap);
    pixel_req_t p;
    p.red   = rgb[23:16];
    p.green = rgb[15:8];
    p.blue  = rgb[7:0];
    p.gap   = 8'(gap);
    pixel_q.push_back(p);
  endtask

  task automatic queue_random(int want, bit quiet, output int sent);
    pixel_req_t p;
    int         k;
    wait_drained();
    sent = safe_run_length(fit_size(cfg_width, FRAME_MAX_W), fit_size(cfg_height, FRAME_MAX_H),
                           want);
    for (k = 0; k < sent; k++) begin
      p.red   = $urandom_range(0, 255);
      p.green = $urandom_range(0, 255);
      p.blue  = $urandom_range(0, 255);
      p.gap   = quiet ? 8'd0 : 8'(pick_gap());
      pixel_q.push_back(p);
    end
  endtask

  // Pixel sender: one request in flight, its gap counted out before it is offered.
  always @(posedge clk) begin : pixel_side
    pixel_req_t front;
    if (rst) begin
      pix_valid <= 1'b0;
    end else begin
      if (pix_valid && pix_bus.ready) begin
        predict_average(offer);
        offer_live = 1'b0;
      end
      if (!offer_live && pixel_q.size() != 0) begin
        if (!gap_armed) begin
          front     = pixel_q[0];
          gap_left  = front.gap;
          gap_armed = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          offer      = pixel_q.pop_front();
          offer_live = 1'b1;
          gap_armed  = 1'b0;
        end
      end
      pix_valid <= offer_live;
      pix_red   <= offer.red;
      pix_green <= offer.green;
      pix_blue  <= offer.blue;
    end
  end

  // Result receiver: random stalls, calm stretches, and one long hold-off while the
  // sender still has plenty queued, so the pipeline fills and pixel ready drops.
  always @(posedge clk) begin : result_side
    int roll;
    bit take;
    if (rst) begin
      avg_ready <= 1'b0;
    end else begin
      if (avg_bus.valid && avg_ready) check_result();
      if (!hold_done && results_seen >= 200 && pixel_q.size() > 30) begin
        hold_left = 96;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        take = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        take = 1'b1;
        if (roll < 2) begin
          calm_left = $urandom_range(50, 300);
        end else if (roll < 5) begin
          stall_left = $urandom_range(10, 40);
          take = 1'b0;
        end else if (roll < 25) begin
          stall_left = $urandom_range(0, 2);
          take = 1'b0;
        end
      end
      avg_ready <= take;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst) begin
      quiet_cycles = 0;
    end else if ((pix_valid && pix_bus.ready) || (avg_bus.valid && avg_ready) ||
                 (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", quiet_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int k;
    int phase;
    int sent;
    int w;
    int h;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    cfg_read(REG_WIDTH, 11'd640);
    cfg_read(REG_HEIGHT, 11'd480);

    // The first frame runs with a count of zero and fills the region that later
    // frames are allowed to revisit.
    set_size(REGION_W, REGION_H);
    for (k = 0; k < 12; k++) queue_pixel(directed_pixel(k), (k % 4 == 3) ? 2 : 0);
    directed_sent += 12;
    queue_random(REGION_W * REGION_H - 12, 1'b0, sent);
    random_sent += sent;

    // Second frame opens with extremes averaged against the first frame's extremes.
    wait_drained();
    for (k = 12; k < 24; k++) queue_pixel(directed_pixel(k), (k % 5 == 4) ? 3 : 0);
    directed_sent += 12;

    for (phase = 0; random_sent < 900 && phase < 400; phase++) begin
      case (phase)
        0:       begin w = 0;          h = 5;          end
        1:       begin w = REGION_W;   h = 0;          end
        2:       begin w = 1024;       h = REGION_H;   end
        3:       begin w = REGION_W;   h = 1024;       end
        4:       begin w = 2047;       h = 2047;       end
        5:       begin w = 1;          h = 1;          end
        6:       begin w = 1023;       h = 1025;       end
        7:       begin w = 12;         h = 8;          end
        default: begin w = pick_dim(REGION_W); h = pick_dim(REGION_H); end
      endcase
      set_size(w, h);
      queue_random(($urandom_range(0, 99) < 85) ? $urandom_range(10, 120)
                                                 : $urandom_range(200, 400),
                   $urandom_range(0, 3) == 0, sent);
      random_sent += sent;
    end

    // A run of one-pixel frames: every pixel revisits the entry of the one before it.
    set_size(1, 1);
    queue_random(100, 1'b1, sat_sent);

    for (phase = 0; random_sent < 1700 && phase < 400; phase++) begin
      set_size(pick_dim(REGION_W), pick_dim(REGION_H));
      queue_random(($urandom_range(0, 99) < 85) ? $urandom_range(10, 120)
                                                 : $urandom_range(200, 400),
                   $urandom_range(0, 3) == 0, sent);
      random_sent += sent;
    end

    wait_drained();
    $display("coverage: %0d directed and %0d random pixels, %0d more in one-pixel frames",
             directed_sent, random_sent, sat_sent);
    $display("coverage: %0d results, %0d frames, %0d size settings, frame count at %0d",
             results_seen, frames_done, sizes_tried, frames_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/fca_pkg.sv
sv/fca_pixel_if.sv
sv/fca_avg_if.sv
sv/fca_regs.sv
sv/fca_seq.sv
sv/fca_lane.sv
sv/fca_merge.sv
sv/frame_cumulative_average.sv
tb/tb_top.sv
